/* rtl/jas_pkg.sv */
// Package with shared constants, register codes, pipeline types and elaboration helpers.
package jas_pkg;

  // Fixed-point one in the Q1.15 convention used throughout (32767 means 1.0).
  localparam logic [14:0] UNIT_ONE   = 15'd32767;
  localparam logic [14:0] SPAN_FLOOR = 15'd3;
  localparam logic [14:0] FD_FLOOR   = 15'd328;
  localparam logic [9:0]  LINEAR_POW = 10'd256;

  // Configuration register indexes.
  typedef enum logic [3:0] {
    REG_AXIS_INDEX   = 4'd0,
    REG_INVERT       = 4'd1,
    REG_DEADZONE     = 4'd2,
    REG_FULL_DEFL    = 4'd3,
    REG_CURVE_POWER  = 4'd4,
    REG_SPRINT_SRC   = 4'd5,
    REG_SPRINT_BTN   = 4'd6,
    REG_SPRINT_LEVEL = 4'd7
  } cfg_reg_t;

  // Pipeline stage record. Fields are reused by the phases that need them.
  typedef struct packed {
    logic        vld;
    logic        zero;
    logic        neg;
    logic        btn;
    logic        sat;
    logic        spr;
    logic [15:0] n;
    logic [15:0] yo;
    logic [29:0] rem;
    logic [14:0] q;
    logic [14:0] u;
    logic [3:0]  lint;
    logic [30:0] y;
    logic [15:0] frac;
    logic [5:0]  k;
    logic [15:0] f;
    logic [30:0] r;
  } stage_t;

  // Integer square root of a 64-bit value, for constant tables.
  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] x;
    r = '0;
    b = 64'd1 << 62;
    x = v;
    for (int j = 0; j < 32; j++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Log2 in Q16 of a 15-bit value by msb search and repeated squaring.
  function automatic logic [19:0] log2_q16(logic [14:0] v);
    logic [3:0]  n;
    logic [63:0] y;
    logic [15:0] fr;
    n = '0;
    fr = '0;
    for (int j = 0; j < 15; j++) begin
      if (v[j]) n = 4'(j);
    end
    y = 64'(v) << (30 - n);
    for (int j = 0; j < 16; j++) begin
      y = (y * y) >> 30;
      fr = {fr[14:0], 1'b0};
      if (y >= (64'd1 << 31)) begin
        fr[0] = 1'b1;
        y = y >> 1;
      end
    end
    return {n, fr};
  endfunction

  // Q30 factors 2^(-2^-i) for i = 1..16.
  function automatic logic [15:0][30:0] pow_table();
    logic [15:0][30:0] t;
    logic [63:0] c;
    c = isqrt64(64'd1 << 59);
    for (int j = 0; j < 16; j++) begin
      t[j] = c[30:0];
      c = isqrt64(c << 30);
    end
    return t;
  endfunction

  localparam logic [19:0]       LOG_ONE = log2_q16(UNIT_ONE);
  localparam logic [15:0][30:0] POW_C   = pow_table();

endpackage

/* rtl/joystick_axis_shaper_unit.sv */
// Top level of the joystick axis shaper: deadzone, scaling, response curve and sprint flag.
//
// A sample is taken whenever start is high; busy never rises, so one sample can
// enter in every cycle. Each sample passes through the register stages in order and
// leaves with result_valid at the last stage. The pipeline holds two 15-step restoring
// dividers, a 16-step log2 squaring chain, and a 16-step exp2 multiply chain, each step
// one register stage. Results cannot be held off; the caller must take them as they appear.
// Configuration is written through the cfg port (always ready); the user must write it
// only while no sample is in flight, as the block itself does not enforce this.
module joystick_axis_shaper_unit #(
  parameter int AXIS_SLOTS   = 8,
  parameter int BUTTON_SLOTS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               device_present,
  input  logic [3:0]         axis_total,
  input  logic signed [15:0] axis_sample,
  input  logic [5:0]         button_total,
  input  logic [31:0]        button_mask,
  output logic               result_valid,
  output logic signed [15:0] shaped_y,
  output logic               sprint_pressed,
  output logic signed [15:0] normalized_raw,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import jas_pkg::*;

  localparam int ST_MUL1 = 1;
  localparam int ST_DIV1 = 2;
  localparam int ST_MUL2 = ST_DIV1 + 15;
  localparam int ST_DIV2 = ST_MUL2 + 1;
  localparam int ST_NORM = ST_DIV2 + 15;
  localparam int ST_LOG  = ST_NORM + 1;
  localparam int ST_EXP0 = ST_LOG + 16;
  localparam int ST_POW  = ST_EXP0 + 1;
  localparam int ST_OUT  = ST_POW + 16;
  localparam int NST     = ST_OUT + 1;

  // Configuration registers.
  logic [2:0]  speed_axis_index;
  logic        invert_sample;
  logic [14:0] deadzone_level;
  logic [14:0] full_deflection;
  logic [9:0]  curve_power;
  logic        sprint_from_button;
  logic [5:0]  sprint_button_index;
  logic [14:0] sprint_level;

  logic [14:0] span;
  logic [14:0] fd;
  logic        in_accept;

  stage_t pipe [NST];
  stage_t nxt  [NST];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_accept = start && !busy;

  // Configuration write transfers.
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_axis_index    <= '0;
      invert_sample       <= 1'b0;
      deadzone_level      <= '0;
      full_deflection     <= 15'd32767;
      curve_power         <= 10'd256;
      sprint_from_button  <= 1'b1;
      sprint_button_index <= '0;
      sprint_level        <= 15'd32767;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_AXIS_INDEX:   speed_axis_index    <= cfg_data[2:0];
        REG_INVERT:       invert_sample       <= cfg_data[0];
        REG_DEADZONE:     deadzone_level      <= cfg_data[14:0];
        REG_FULL_DEFL:    full_deflection     <= cfg_data[14:0];
        REG_CURVE_POWER:  curve_power         <= cfg_data[9:0];
        REG_SPRINT_SRC:   sprint_from_button  <= cfg_data[0];
        REG_SPRINT_BTN:   sprint_button_index <= cfg_data[5:0];
        REG_SPRINT_LEVEL: sprint_level        <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Divisors derived from configuration, with their floors.
  always_comb begin
    span = (deadzone_level < UNIT_ONE) ? (UNIT_ONE - deadzone_level) : '0;
    if (span < SPAN_FLOOR) span = SPAN_FLOOR;
    fd = (full_deflection < FD_FLOOR) ? FD_FLOOR : full_deflection;
  end

  // Entry stage: clamp, invert, magnitude past the deadzone, button lookup.
  always_comb begin
    logic signed [15:0] nv;
    logic [14:0]        m;
    logic signed [6:0]  bi;
    nxt[0] = '0;
    nxt[0].vld = in_accept && !rst;
    nv = (axis_sample == -16'sd32768) ? -16'sd32767 : axis_sample;
    if (invert_sample) nv = -nv;
    m = nv[15] ? 15'(-nv) : nv[14:0];
    nxt[0].n    = nv;
    nxt[0].neg  = nv[15];
    nxt[0].zero = !device_present || ({1'b0, speed_axis_index} >= axis_total) ||
                  (int'(speed_axis_index) >= AXIS_SLOTS);
    nxt[0].rem  = (m > deadzone_level) ? 30'(m - deadzone_level) : '0;
    bi = 7'(signed'(sprint_button_index));
    nxt[0].btn = !bi[6] && (bi[5:0] < button_total) && (int'(bi) < BUTTON_SLOTS) &&
                 (bi[5:0] < 6'd32) && button_mask[bi[4:0]];
  end

  // Later stages: each a multiply, divide step, normalize, squaring, exponent setup, exp step or output stage.
  always_comb begin
    logic [29:0] dsh;
    logic [14:0] dv;
    logic [14:0] t;
    logic [63:0] sq;
    logic [61:0] pr;
    logic [29:0] ep;
    logic [45:0] fin;
    logic [15:0] res;
    logic [14:0] uo;
    logic [15:0] yv;
    int          i;
    dsh = '0;
    dv  = '0;
    t   = '0;
    sq  = '0;
    pr  = '0;
    ep  = '0;
    fin = '0;
    res = '0;
    uo  = '0;
    yv  = '0;
    i   = 0;
    for (int s = 1; s < NST; s++) begin
      nxt[s] = pipe[s-1];
      nxt[s].vld = pipe[s-1].vld && !rst;
      if (s == ST_MUL1) begin
        nxt[s].rem = 30'(pipe[s-1].rem[14:0]) * 30'(UNIT_ONE);
        nxt[s].q   = '0;
      end else if ((s >= ST_DIV1 && s < ST_MUL2) || (s >= ST_DIV2 && s < ST_NORM)) begin
        // Restoring division step; the first step also flags an overflowing quotient.
        dv  = (s < ST_MUL2) ? span : fd;
        i   = (s < ST_MUL2) ? 14 - (s - ST_DIV1) : 14 - (s - ST_DIV2);
        if (i == 14) nxt[s].sat = (pipe[s-1].rem >= ({15'd0, dv} << 15));
        dsh = {15'd0, dv} << i;
        if (pipe[s-1].rem >= dsh) begin
          nxt[s].rem  = pipe[s-1].rem - dsh;
          nxt[s].q[i] = 1'b1;
        end
      end else if (s == ST_MUL2) begin
        t = pipe[s-1].sat ? UNIT_ONE : pipe[s-1].q;
        nxt[s].rem = 30'(t) * 30'(UNIT_ONE);
        nxt[s].q   = '0;
        nxt[s].sat = 1'b0;
      end else if (s == ST_NORM) begin
        // Clamp the scaled value and normalize it into a Q30 mantissa.
        uo = pipe[s-1].sat ? UNIT_ONE : pipe[s-1].q;
        nxt[s].u    = uo;
        nxt[s].lint = '0;
        for (int j = 0; j < 15; j++) begin
          if (uo[j]) nxt[s].lint = 4'(j);
        end
        nxt[s].y    = 31'(31'(uo) << (5'd30 - 5'(nxt[s].lint)));
        nxt[s].frac = '0;
      end else if (s >= ST_LOG && s < ST_EXP0) begin
        // One fraction bit of log2 per squaring.
        sq = 64'(pipe[s-1].y) * 64'(pipe[s-1].y);
        sq = sq >> 30;
        nxt[s].frac = {pipe[s-1].frac[14:0], 1'b0};
        if (sq[31]) begin
          nxt[s].frac[0] = 1'b1;
          sq = sq >> 1;
        end
        nxt[s].y = sq[30:0];
      end else if (s == ST_EXP0) begin
        ep = 30'(LOG_ONE - {pipe[s-1].lint, pipe[s-1].frac}) * 30'(curve_power);
        nxt[s].k = ep[29:24];
        nxt[s].f = ep[23:8];
        nxt[s].r = 31'd1 << 30;
      end else if (s >= ST_POW && s < ST_OUT) begin
        // Multiply in 2^(-2^-i) for each set fraction bit of the exponent.
        i = s - ST_POW;
        if (pipe[s-1].f[15 - i]) begin
          pr = 62'(pipe[s-1].r) * 62'(POW_C[i]);
          nxt[s].r = pr[60:30];
        end
      end else if (s == ST_OUT) begin
        fin = 46'(pipe[s-1].r) * 46'(UNIT_ONE);
        res = fin[45:30];
        res = pipe[s-1].k[5] ? 16'd0 : (res >> pipe[s-1].k[4:0]);
        uo  = (res > 16'(UNIT_ONE)) ? UNIT_ONE : res[14:0];
        if (curve_power == LINEAR_POW) uo = pipe[s-1].u;
        else if (curve_power == 10'd0) uo = UNIT_ONE;
        else if (pipe[s-1].u == '0)    uo = '0;
        yv = pipe[s-1].neg ? -{1'b0, uo} : {1'b0, uo};
        nxt[s].yo  = yv;
        nxt[s].spr = sprint_from_button ? pipe[s-1].btn :
                     ($signed({yv[15], yv}) >= $signed({2'b00, sprint_level}));
        if (pipe[s-1].zero) begin
          nxt[s].yo  = '0;
          nxt[s].spr = 1'b0;
          nxt[s].n   = '0;
        end
      end
    end
  end

  // Stage registers; reset clears only the valid bits, through the next-state logic.
  always_ff @(posedge clk) begin
    for (int s = 0; s < NST; s++) begin
      pipe[s] <= nxt[s];
    end
  end

  assign result_valid   = pipe[NST-1].vld;
  assign shaped_y       = pipe[NST-1].yo;
  assign sprint_pressed = pipe[NST-1].spr;
  assign normalized_raw = pipe[NST-1].n;

  // Every transfer is followed by a result at the end of the pipeline.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_accept |-> ##68 result_valid) else $error("result missing after latency");

  // A result never appears without a sample that entered the pipeline.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(in_accept, 68)) else $error("result without a sample");

  // A negative shaped value needs a negative normalized sample.
  a_sign: assert property (@(posedge clk) disable iff (rst)
    (result_valid && shaped_y[15]) |-> normalized_raw[15]) else $error("sign mismatch");

  // The shaped value stays within plus or minus one.
  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (shaped_y != 16'h8000)) else $error("shaped value out of range");

endmodule

/* test/jas_checker.sv */
// Checker for the joystick axis shaper: predicts each result and compares it with the block.
module jas_checker
  import jas_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               device_present,
  input  logic [3:0]         axis_total,
  input  logic signed [15:0] axis_sample,
  input  logic [5:0]         button_total,
  input  logic [31:0]        button_mask,
  input  logic               result_valid,
  input  logic signed [15:0] shaped_y,
  input  logic               sprint_pressed,
  input  logic signed [15:0] normalized_raw,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 mismatch_count,
  output int                 pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] y;
    logic               spr;
    logic signed [15:0] n;
  } shape_result_t;

  // Local copy of the register file.
  logic [2:0]  axis_sel;
  logic        invert_on;
  logic [14:0] dz_level;
  logic [14:0] full_defl;
  logic [9:0]  power_q8;
  logic        spr_by_button;
  logic [5:0]  spr_button;
  logic [14:0] spr_level;

  shape_result_t expected_results[$];
  logic [63:0] exp2_factor[16];

  assign pending_count = expected_results.size();

  // Integer square root by the restoring bit method.
  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Log2 in Q16 from the msb position and squaring of the mantissa.
  function automatic logic [31:0] log2_fixed(logic [31:0] v);
    logic [31:0] msb;
    logic [31:0] fr;
    logic [63:0] mant;
    msb = 0;
    fr = 0;
    while (msb < 31 && (v >> (msb + 1)) != 0) msb++;
    mant = 64'(v) << (30 - msb);
    for (int i = 0; i < 16; i++) begin
      mant = (mant * mant) >> 30;
      fr = fr << 1;
      if (mant >= (64'd1 << 31)) begin
        fr = fr | 1;
        mant = mant >> 1;
      end
    end
    return (msb << 16) | fr;
  endfunction

  // Response curve: u raised to p/256, relative to full scale.
  function automatic logic [31:0] curve(logic [31:0] u, logic [31:0] p);
    logic [63:0] e;
    logic [63:0] r;
    logic [63:0] res;
    logic [31:0] k;
    logic [31:0] f;
    if (p == 256) return u;
    if (p == 0) return 32767;
    if (u == 0) return 0;
    e = (64'(log2_fixed(32767) - log2_fixed(u)) * p) >> 8;
    k = e[47:16];
    f = {16'd0, e[15:0]};
    r = 64'd1 << 30;
    for (int i = 0; i < 16; i++)
      if (f[15 - i]) r = (r * exp2_factor[i]) >> 30;
    if (k >= 32) return 0;
    res = ((64'd32767 * r) >> 30) >> k;
    return res > 32767 ? 32767 : 32'(res);
  endfunction

  // Full shaping of one sample under the current registers.
  function automatic shape_result_t shape_sample(logic present, logic [3:0] axes,
      logic signed [15:0] raw, logic [5:0] buttons, logic [31:0] mask);
    shape_result_t res;
    int n;
    int m;
    int span;
    int fd;
    int btn;
    logic [63:0] q;
    logic [31:0] t;
    logic [31:0] u;
    int y;
    res = '0;
    if (!present || axis_sel >= axes) return res;
    n = raw;
    if (n < -32767) n = -32767;
    if (invert_on) n = -n;
    m = n < 0 ? -n : n;
    span = (dz_level < 32767) ? 32767 - dz_level : 0;
    if (span < 3) span = 3;
    t = 0;
    if (m > dz_level) begin
      q = (64'(m - dz_level) * 32767) / span;
      t = q > 32767 ? 32767 : 32'(q);
    end
    fd = full_defl < 328 ? 328 : full_defl;
    q = (64'(t) * 32767) / fd;
    u = q > 32767 ? 32767 : 32'(q);
    u = curve(u, power_q8);
    y = n < 0 ? -int'(u) : int'(u);
    if (spr_by_button) begin
      btn = $signed(spr_button);
      res.spr = btn >= 0 && btn < buttons && btn < 32 && mask[btn[4:0]];
    end else begin
      res.spr = y >= int'(spr_level);
    end
    res.y = y[15:0];
    res.n = n[15:0];
    return res;
  endfunction

  initial begin
    logic [63:0] c;
    c = int_sqrt(64'd1 << 59);
    for (int i = 0; i < 16; i++) begin
      exp2_factor[i] = c;
      c = int_sqrt(c << 30);
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Register writes, sample transfers and result comparison.
  always @(posedge clk) begin
    shape_result_t want;
    if (rst) begin
      axis_sel <= '0;
      invert_on <= 1'b0;
      dz_level <= '0;
      full_defl <= 15'd32767;
      power_q8 <= 10'd256;
      spr_by_button <= 1'b1;
      spr_button <= '0;
      spr_level <= 15'd32767;
      mismatch_count = 0;
    end else begin
      if (start && !busy)
        expected_results.insert(expected_results.size(),
                                shape_sample(device_present, axis_total, axis_sample,
                                             button_total, button_mask));
      if (result_valid) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, shaped_y", shaped_y, 0);
        end else begin
          want = expected_results.pop_front();
          if (shaped_y !== want.y) report_mismatch("shaped_y", shaped_y, want.y);
          if (sprint_pressed !== want.spr)
            report_mismatch("sprint_pressed", sprint_pressed, want.spr);
          if (normalized_raw !== want.n)
            report_mismatch("normalized_raw", normalized_raw, want.n);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_AXIS_INDEX:   axis_sel <= cfg_data[2:0];
          REG_INVERT:       invert_on <= cfg_data[0];
          REG_DEADZONE:     dz_level <= cfg_data[14:0];
          REG_FULL_DEFL:    full_defl <= cfg_data[14:0];
          REG_CURVE_POWER:  power_q8 <= cfg_data[9:0];
          REG_SPRINT_SRC:   spr_by_button <= cfg_data[0];
          REG_SPRINT_BTN:   spr_button <= cfg_data[5:0];
          REG_SPRINT_LEVEL: spr_level <= cfg_data[14:0];
          default: ;
        endcase
      end
    end
  end
endmodule

/* test/testbench.sv */
// Testbench top for the joystick axis shaper: stimulus, configuration phases and verdict.
module testbench;
  import jas_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               device_present;
  logic [3:0]         axis_total;
  logic signed [15:0] axis_sample;
  logic [5:0]         button_total;
  logic [31:0]        button_mask;
  logic               result_valid;
  logic signed [15:0] shaped_y;
  logic               sprint_pressed;
  logic signed [15:0] normalized_raw;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [3:0]         cfg_index;
  logic [15:0]        cfg_data;
  int                 mismatch_count;
  int                 pending_count;

  joystick_axis_shaper_unit i_dut (.*);

  jas_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Generous limit on the whole run.
  initial begin
    #3ms;
    $display("Mismatches found");
    $finish;
  end

  // One configuration transfer; the channel is then left idle before the task returns.
  task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every result is in, then let the pipeline drain.
  task automatic drain();
    while (pending_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Idle stretch between samples: mostly short, now and then long.
  task automatic idle_gap();
    int pick;
    pick = $urandom_range(0, 99);
    repeat (pick < 92 ? $urandom_range(1, 3) : $urandom_range(10, 90)) @(posedge clk);
  endtask

  // One sample transfer; start stays high across back-to-back samples.
  task automatic send_sample(logic present, logic [3:0] axes, logic [15:0] raw,
                             logic [5:0] buttons, logic [31:0] mask, bit gaps);
    start <= 1'b1;
    device_present <= present;
    axis_total <= axes;
    axis_sample <= raw;
    button_total <= buttons;
    button_mask <= mask;
    do @(posedge clk); while (busy);
    if (gaps && $urandom_range(0, 1)) begin
      start <= 1'b0;
      idle_gap();
    end
  endtask

  task automatic random_sample(bit gaps);
    logic [15:0] raw;
    int pick;
    pick = $urandom_range(0, 9);
    raw = pick == 0 ? 16'h8000 : pick == 1 ? 16'h7fff : 16'($urandom);
    send_sample($urandom_range(0, 15) != 0,
                $urandom_range(0, 9) == 0 ? 4'($urandom) : 4'd8,
                raw,
                $urandom_range(0, 5) == 0 ? 6'($urandom) : 6'($urandom_range(20, 32)),
                $urandom, gaps);
  endtask

  task automatic random_config();
    logic [15:0] dz;
    logic [15:0] fd;
    logic [15:0] pw;
    dz = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 16384));
    fd = $urandom_range(0, 4) == 0 ? 16'($urandom_range(0, 400)) :
                                     16'($urandom_range(328, 32767));
    pw = $urandom_range(0, 4) == 0 ? 16'($urandom) : 16'($urandom_range(128, 768));
    write_reg(REG_AXIS_INDEX, 16'($urandom_range(0, 7)));
    write_reg(REG_INVERT, 16'($urandom_range(0, 1)));
    write_reg(REG_DEADZONE, dz);
    write_reg(REG_FULL_DEFL, fd);
    write_reg(REG_CURVE_POWER, pw);
    write_reg(REG_SPRINT_SRC, 16'($urandom_range(0, 1)));
    write_reg(REG_SPRINT_BTN, 16'($urandom));
    write_reg(REG_SPRINT_LEVEL, $urandom_range(0, 2) == 0 ? 16'($urandom) :
                                                             16'($urandom_range(0, 32767)));
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    device_present <= 1'b0;
    axis_total <= '0;
    axis_sample <= '0;
    button_total <= '0;
    button_mask <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_AXIS_INDEX;
    cfg_data <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed samples under reset settings: extremes, absent device, axis out of range.
    send_sample(1'b1, 4'd8, 16'sh8000, 6'd32, 32'h1, 1'b0);
    send_sample(1'b1, 4'd8, 16'sh8001, 6'd32, 32'h0, 1'b0);
    send_sample(1'b1, 4'd8, 16'sh7fff, 6'd1, 32'hffffffff, 1'b0);
    send_sample(1'b1, 4'd8, 16'sh0000, 6'd0, 32'hffffffff, 1'b0);
    send_sample(1'b0, 4'd8, 16'sh4000, 6'd32, 32'h1, 1'b0);
    send_sample(1'b1, 4'd0, 16'sh4000, 6'd32, 32'h1, 1'b0);
    send_sample(1'b1, 4'd15, 16'shc000, 6'd63, 32'h1, 1'b0);
    start <= 1'b0;
    drain();

    // Directed extreme settings: inverted, deep deadzone, low full point, curves, threshold.
    write_reg(REG_AXIS_INDEX, 16'd7);
    write_reg(REG_INVERT, 16'd1);
    write_reg(REG_DEADZONE, 16'h7fff);
    write_reg(REG_FULL_DEFL, 16'd0);
    write_reg(REG_CURVE_POWER, 16'd0);
    write_reg(REG_SPRINT_SRC, 16'd0);
    write_reg(REG_SPRINT_BTN, 16'h3f);
    write_reg(REG_SPRINT_LEVEL, 16'd0);
    send_sample(1'b1, 4'd7, 16'sh1000, 6'd32, 32'h1, 1'b0);
    send_sample(1'b1, 4'd8, 16'sh8000, 6'd32, 32'h1, 1'b0);
    send_sample(1'b1, 4'd8, 16'sh7fff, 6'd32, 32'h1, 1'b0);
    start <= 1'b0;
    drain();
    write_reg(REG_DEADZONE, 16'd16384);
    write_reg(REG_FULL_DEFL, 16'd328);
    write_reg(REG_CURVE_POWER, 16'h3ff);
    write_reg(REG_SPRINT_LEVEL, 16'h7fff);
    write_reg(REG_INVERT, 16'd0);
    for (int i = 0; i < 6; i++)
      send_sample(1'b1, 4'd8, 16'(i * 5000 - 12000), 6'd32, 32'h0, 1'b0);
    start <= 1'b0;
    drain();
    write_reg(REG_CURVE_POWER, 16'd128);
    write_reg(REG_SPRINT_SRC, 16'd1);
    write_reg(REG_SPRINT_BTN, 16'd31);
    write_reg(REG_DEADZONE, 16'd0);
    write_reg(REG_FULL_DEFL, 16'd32767);
    send_sample(1'b1, 4'd8, 16'sh0001, 6'd32, 32'h80000000, 1'b0);
    send_sample(1'b1, 4'd8, 16'sh2000, 6'd31, 32'h80000000, 1'b0);
    start <= 1'b0;
    drain();
    write_reg(REG_CURVE_POWER, 16'd768);
    send_sample(1'b1, 4'd8, 16'sh2000, 6'd32, 32'h80000000, 1'b0);
    start <= 1'b0;
    drain();

    // Random phases, each under fresh settings.
    for (int phase = 0; phase < 24; phase++) begin
      random_config();
      for (int i = 0; i < 80; i++) random_sample(phase % 3 != 0);
      start <= 1'b0;
      drain();
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
